/* hw/rtl/sdcr_pkg.sv */
`timescale 1ns / 1ps

package sdcr_pkg;

	localparam int WORD_W   = 24;
	localparam int STATUS_W = 3;
	localparam int STATE_W  = 4;
	localparam int CRC_W    = 7;
	localparam int FRAME_W  = 40;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	typedef logic [WORD_W-1:0]   word_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [STATE_W-1:0]  card_state_t;

	// Result status codes
	localparam status_t ST_CRC_ERR   = 3'd0;
	localparam status_t ST_NOT_HOST  = 3'd1;
	localparam status_t ST_NO_REPLY  = 3'd2;
	localparam status_t ST_R1        = 3'd3;
	localparam status_t ST_R3        = 3'd4;
	localparam status_t ST_R6_UNSUPP = 3'd5;
	localparam status_t ST_INVALID   = 3'd6;

	// Command indexes that the decoder knows
	localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
	localparam logic [5:0] CMD_SEND_OP   = 6'd1;
	localparam logic [5:0] CMD_ALL_CID   = 6'd2;
	localparam logic [5:0] CMD_REL_ADDR  = 6'd3;
	localparam logic [5:0] CMD_APP_OP    = 6'd41;
	localparam logic [5:0] CMD_APP_CMD   = 6'd55;

	// Frame header: start and host bits
	localparam logic [7:0] HDR_MASK = 8'hC0;
	localparam logic [7:0] HDR_HOST = 8'h40;

	// Fixed R3 words
	localparam word_t R3_FIRST  = 24'h3F80FF;
	localparam word_t R3_SECOND = 24'h8000FF;

	// R1 status byte with the application bit set
	localparam logic [7:0] R1_APP_BYTE = 8'h20;

	// Register indexes
	localparam int REG_CARD_STATE = 0;

	// CRC7 (x^7 + x^3 + 1) remainder left by a single one at bit pos of a
	// 40-bit frame sent MSB first; used to build constant XOR columns.
	function automatic logic [CRC_W-1:0] crc7_col(input int pos);
		logic [CRC_W-1:0] crc;
		logic             fb;
		crc = '0;
		for (int b = FRAME_W - 1; b >= 0; b--) begin
			fb  = (b == pos) ^ crc[CRC_W-1];
			crc = {crc[CRC_W-2:0], 1'b0};
			if (fb) begin
				crc = crc ^ 7'h09;
			end
		end
		return crc;
	endfunction

endpackage

/* hw/rtl/sd_command_responder_core.sv */
`timescale 1ns / 1ps

// SD command responder: takes one 48-bit command frame per beat as two 24-bit
// words, checks its CRC7 and start/host bits, decodes the command index and
// returns one result beat per frame (status, two response words, application
// mode). The whole check and decode happens in the accept cycle; the result is
// shown from an output register. While results drain freely a new frame is taken
// every cycle; a one-entry skid stage takes one more frame while a result waits,
// then in_stall rises. in_stall is high only while the skid stage is full, and
// drops in the cycle after the waiting result leaves. The user writes card_state
// (APB port, address 0) only while the block is idle; the block does not check.
module sd_command_responder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sdcr_pkg::PADDR_W-1:0]  paddr,
	input  logic [sdcr_pkg::PDATA_W-1:0]  pwdata,
	output logic [sdcr_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	// Frame input
	input  logic                          in_valid,
	output logic                          in_stall,
	input  sdcr_pkg::word_t               word_first,
	input  sdcr_pkg::word_t               word_second,
	// Result output
	output logic                          out_valid,
	input  logic                          out_stall,
	output sdcr_pkg::status_t             status,
	output sdcr_pkg::word_t               resp_first,
	output sdcr_pkg::word_t               resp_second,
	output logic                          app_mode_out
);
	import sdcr_pkg::*;

	typedef struct packed {
		status_t status;
		word_t   resp_first;
		word_t   resp_second;
		logic    app_mode;
	} result_t;

	card_state_t card_state_q;
	logic        app_mode_q;
	logic        wr_en;
	logic        reg_sel;

	logic        in_acc;
	logic        out_acc;
	logic        out_valid_q;
	logic        skid_valid_q;
	result_t     out_q;
	result_t     skid_q;
	result_t     res;

	logic [7:0]  rx_trailer;
	logic [7:0]  tx_trailer;
	logic [7:0]  hdr;
	logic [5:0]  cmd;
	word_t       r1_second;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1:2] == REG_CARD_STATE[PADDR_W-3:0]);
	assign wr_en   = psel & penable & pwrite & reg_sel;
	assign prdata  = reg_sel ? {{(PDATA_W-STATE_W){1'b0}}, card_state_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			card_state_q <= '0;
		end else if (wr_en) begin
			card_state_q <= pwdata[STATE_W-1:0];
		end
	end

	// Check the received frame CRC
	sdcr_crc7 u_rx_crc (
		.data    ({word_first, word_second[WORD_W-1:8]}),
		.trailer (rx_trailer)
	);

	// R1 body for CMD55, then its CRC
	assign r1_second = {3'b000, card_state_q, 1'b0, R1_APP_BYTE, 8'h00};

	sdcr_crc7 u_tx_crc (
		.data    ({2'b00, CMD_APP_CMD, 16'h0000, r1_second[WORD_W-1:8]}),
		.trailer (tx_trailer)
	);

	assign hdr = word_first[WORD_W-1:WORD_W-8];
	assign cmd = hdr[5:0];

	// Decode one frame
	always_comb begin
		res.status      = ST_INVALID;
		res.resp_first  = '0;
		res.resp_second = '0;
		res.app_mode    = app_mode_q;
		if (word_second[7:0] != rx_trailer) begin
			res.status = ST_CRC_ERR;
		end else if ((hdr & HDR_MASK) != HDR_HOST) begin
			res.status = ST_NOT_HOST;
		end else begin
			res.app_mode = 1'b0;
			case (cmd)
				CMD_GO_IDLE, CMD_SEND_OP: begin
					res.status   = ST_NO_REPLY;
					res.app_mode = app_mode_q;
				end
				CMD_ALL_CID, CMD_APP_OP: begin
					res.status      = ST_R3;
					res.resp_first  = R3_FIRST;
					res.resp_second = R3_SECOND;
				end
				CMD_REL_ADDR: begin
					res.status = ST_R6_UNSUPP;
				end
				CMD_APP_CMD: begin
					res.status      = ST_R1;
					res.app_mode    = 1'b1;
					res.resp_first  = {2'b00, CMD_APP_CMD, 16'h0000};
					res.resp_second = {r1_second[WORD_W-1:8], tx_trailer};
				end
				default: begin
					res.status = ST_INVALID;
				end
			endcase
		end
	end

	// Handshakes
	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid & ~skid_valid_q;
	assign out_acc  = out_valid_q & ~out_stall;

	// Advance application mode in frame order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			app_mode_q <= 1'b0;
		end else if (in_acc) begin
			app_mode_q <= res.app_mode;
		end
	end

	// Output register and skid stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_acc) begin
					skid_valid_q <= 1'b0;
				end
			end else if (in_acc && out_valid_q && !out_acc) begin
				skid_valid_q <= 1'b1;
			end
			if (in_acc || skid_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payloads: load output when free, else hold in skid
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_acc) begin
				out_q <= skid_q;
			end
		end else if (in_acc) begin
			if (!out_valid_q || out_acc) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign resp_first   = out_q.resp_first;
	assign resp_second  = out_q.resp_second;
	assign app_mode_out = out_q.app_mode;

endmodule

/* hw/rtl/sdcr_crc7.sv */
`timescale 1ns / 1ps

module sdcr_crc7 (
	input  logic [sdcr_pkg::FRAME_W-1:0] data,
	output logic [7:0]                   trailer
);
	import sdcr_pkg::*;

	logic [CRC_W-1:0] term [FRAME_W];
	logic [CRC_W-1:0] crc;

	// Each data bit contributes a fixed remainder column
	for (genvar g = 0; g < FRAME_W; g++) begin : g_col
		localparam logic [CRC_W-1:0] COL = crc7_col(g);
		assign term[g] = data[g] ? COL : '0;
	end

	// Fold the columns together
	always_comb begin
		crc = '0;
		for (int i = 0; i < FRAME_W; i++) begin
			crc = crc ^ term[i];
		end
	end

	assign trailer = {crc, 1'b1};

endmodule

/* dv/sd_command_responder_core_tb.sv */
`timescale 1ns / 1ps

module sd_command_responder_core_tb;

	import sdcr_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLDOFF_LEN  = 300;
	localparam int PHASE_ITEMS  = 200;
	localparam int PHASE_COUNT  = 8;

	localparam logic [PADDR_W-1:0] ADDR_CARD_STATE = PADDR_W'(REG_CARD_STATE * 4);
	localparam logic [PADDR_W-1:0] ADDR_NO_REG     = PADDR_W'((REG_CARD_STATE + 1) * 4);

	localparam logic [1:0] HDR_BITS_HOST = HDR_HOST[7:6];

	typedef struct packed {
		status_t status;
		word_t   resp_first;
		word_t   resp_second;
		logic    app_mode;
	} reply_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                in_valid;
	logic                in_stall;
	word_t               word_first;
	word_t               word_second;
	logic                out_valid;
	logic                out_stall;
	status_t             status;
	word_t               resp_first;
	word_t               resp_second;
	logic                app_mode_out;

	reply_t      pending_replies[$];
	card_state_t card_state_mirror;
	logic        app_mode_mirror;
	int unsigned errors;
	int unsigned cycles;
	logic        steady_in;
	logic        steady_out;
	logic        holdoff_req;
	int          holdoff_left;

	sd_command_responder_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.word_first   (word_first),
		.word_second  (word_second),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.resp_first   (resp_first),
		.resp_second  (resp_second),
		.app_mode_out (app_mode_out)
	);

	// Free-running clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// CRC7 over 40 bits sent MSB first, returned with the end bit appended
	function automatic logic [7:0] frame_crc_byte(input logic [39:0] bits);
		logic [6:0] crc;
		logic       fb;
		crc = '0;
		for (int i = 39; i >= 0; i--) begin
			fb  = bits[i] ^ crc[6];
			crc = {crc[5:0], 1'b0};
			if (fb) begin
				crc = crc ^ 7'h09;
			end
		end
		return {crc, 1'b1};
	endfunction

	// Build a frame with a correct trailer
	function automatic logic [47:0] host_frame(input logic [1:0] hdr, input logic [5:0] cmd,
			input logic [31:0] arg);
		logic [39:0] body;
		body = {hdr, cmd, arg};
		return {body, frame_crc_byte(body)};
	endfunction

	// Work out the reply to one frame and advance the application mode
	task automatic decode_command(input word_t w0, input word_t w1, output reply_t r);
		logic [5:0] cmd;
		cmd           = w0[21:16];
		r.status      = ST_INVALID;
		r.resp_first  = '0;
		r.resp_second = '0;
		if (w1[7:0] != frame_crc_byte({w0, w1[23:8]})) begin
			r.status = ST_CRC_ERR;
		end else if ((w0[23:16] & HDR_MASK) != HDR_HOST) begin
			r.status = ST_NOT_HOST;
		end else begin
			case (cmd)
				CMD_GO_IDLE, CMD_SEND_OP: begin
					r.status = ST_NO_REPLY;
				end
				CMD_ALL_CID, CMD_APP_OP: begin
					r.status      = ST_R3;
					r.resp_first  = R3_FIRST;
					r.resp_second = R3_SECOND;
				end
				CMD_REL_ADDR: begin
					r.status = ST_R6_UNSUPP;
				end
				CMD_APP_CMD: begin
					app_mode_mirror      = 1'b1;
					r.status             = ST_R1;
					r.resp_first         = {2'b00, cmd, 16'h0000};
					r.resp_second[23:16] = {3'b000, card_state_mirror, 1'b0};
					r.resp_second[15:8]  = R1_APP_BYTE;
					r.resp_second[7:0]   = frame_crc_byte({r.resp_first, r.resp_second[23:8]});
				end
				default: begin
					r.status = ST_INVALID;
				end
			endcase
			if (cmd != CMD_GO_IDLE && cmd != CMD_SEND_OP && cmd != CMD_APP_CMD) begin
				app_mode_mirror = 1'b0;
			end
		end
		r.app_mode = app_mode_mirror;
	endtask

	// Offer one frame, wait for the beat, then record its reply
	task automatic send_frame(input word_t w0, input word_t w1);
		reply_t r;
		if (!steady_in) begin
			while ($urandom_range(99) < 29) begin
				in_valid    <= 1'b0;
				word_first  <= word_t'($urandom);
				word_second <= word_t'($urandom);
				@(posedge clk);
			end
		end
		in_valid    <= 1'b1;
		word_first  <= w0;
		word_second <= w1;
		do begin
			@(posedge clk);
		end while (in_stall);
		decode_command(w0, w1, r);
		pending_replies.push_back(r);
	endtask

	task automatic send_cmd(input logic [1:0] hdr, input logic [5:0] cmd, input logic [31:0] arg);
		logic [47:0] f;
		f = host_frame(hdr, cmd, arg);
		send_frame(f[47:24], f[23:0]);
	endtask

	// Drop valid and wait until every reply is back
	task automatic drain_replies();
		in_valid <= 1'b0;
		wait (pending_replies.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	// One APB transfer: setup cycle, then access until pready
	task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] data, output logic [PDATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		rdata = prdata;
		if (wr && addr == ADDR_CARD_STATE) begin
			card_state_mirror = data[STATE_W-1:0];
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_card_state(input card_state_t cs);
		logic [PDATA_W-1:0] rd;
		logic [PDATA_W-1:0] wd;
		wd                = $urandom;
		wd[STATE_W-1:0]   = cs;
		apb_xfer(1'b1, ADDR_CARD_STATE, wd, rd);
		apb_xfer(1'b0, ADDR_CARD_STATE, '0, rd);
		if (rd !== PDATA_W'(card_state_mirror)) begin
			$error("card_state readback: expected %0h, got %0h", card_state_mirror, rd);
			errors++;
		end
	endtask

	// Field extremes, every command, and the mode-keeping cases
	task automatic test_directed();
		logic [47:0] f;
		send_frame(24'h000000, 24'h000000);
		send_frame(24'hFFFFFF, 24'hFFFFFF);
		send_cmd(HDR_BITS_HOST, CMD_GO_IDLE, 32'h0000_0000);
		send_cmd(HDR_BITS_HOST, CMD_APP_CMD, 32'hFFFF_FFFF);
		send_cmd(HDR_BITS_HOST, CMD_GO_IDLE, 32'hFFFF_FFFF);
		send_cmd(HDR_BITS_HOST, CMD_SEND_OP, 32'h8000_0001);
		send_cmd(HDR_BITS_HOST, CMD_APP_CMD, 32'h0000_0000);
		// bad CRC and wrong end bit keep the mode
		f = host_frame(HDR_BITS_HOST, CMD_ALL_CID, 32'h1234_5678);
		send_frame(f[47:24], f[23:0] ^ 24'h000001);
		f = host_frame(HDR_BITS_HOST, CMD_APP_OP, 32'h0000_0000);
		send_frame(f[47:24], f[23:0] ^ 24'h000080);
		// not a host frame keeps the mode too
		send_cmd(2'b11, CMD_APP_OP, 32'h0000_0000);
		send_cmd(2'b00, CMD_ALL_CID, 32'hFFFF_FFFF);
		send_cmd(2'b10, CMD_APP_CMD, 32'h5555_AAAA);
		send_cmd(HDR_BITS_HOST, CMD_ALL_CID, 32'hAAAA_5555);
		send_cmd(HDR_BITS_HOST, CMD_APP_CMD, 32'h0000_0000);
		send_cmd(HDR_BITS_HOST, CMD_APP_OP, 32'h40FF_8000);
		send_cmd(HDR_BITS_HOST, CMD_APP_CMD, 32'h0000_0000);
		send_cmd(HDR_BITS_HOST, CMD_REL_ADDR, 32'h0000_0000);
		send_cmd(HDR_BITS_HOST, CMD_APP_CMD, 32'h0000_0000);
		send_cmd(HDR_BITS_HOST, 6'd63, 32'hFFFF_FFFF);
		send_cmd(HDR_BITS_HOST, 6'd17, 32'h0000_0200);
		drain_replies();
	endtask

	// Register extremes, readback, and a write to an unmapped index
	task automatic test_config();
		logic [PDATA_W-1:0] rd;
		apb_xfer(1'b0, ADDR_CARD_STATE, '0, rd);
		if (rd !== PDATA_W'(0)) begin
			$error("card_state after reset: expected 0, got %0h", rd);
			errors++;
		end
		set_card_state(4'hF);
		send_cmd(HDR_BITS_HOST, CMD_APP_CMD, 32'h0);
		drain_replies();
		apb_xfer(1'b1, ADDR_NO_REG, 32'h0000_0000, rd);
		apb_xfer(1'b0, ADDR_CARD_STATE, '0, rd);
		if (rd !== PDATA_W'(card_state_mirror)) begin
			$error("card_state after unmapped write: expected %0h, got %0h",
				card_state_mirror, rd);
			errors++;
		end
		send_cmd(HDR_BITS_HOST, CMD_APP_CMD, 32'h0);
		drain_replies();
		set_card_state(4'h0);
		send_cmd(HDR_BITS_HOST, CMD_APP_CMD, 32'hFFFF_FFFF);
		drain_replies();
		set_card_state(4'hA);
		send_cmd(HDR_BITS_HOST, CMD_APP_CMD, 32'h1);
		drain_replies();
	endtask

	// Random frames, mostly well formed, in phases with different card states
	task automatic test_random();
		logic [47:0] f;
		logic [5:0]  cmd;
		logic [1:0]  hdr;
		int          kind;
		logic [5:0]  known[6];
		known = '{CMD_GO_IDLE, CMD_SEND_OP, CMD_ALL_CID, CMD_REL_ADDR, CMD_APP_OP, CMD_APP_CMD};
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0:       set_card_state(4'h0);
				1:       set_card_state(4'hF);
				default: set_card_state(card_state_t'($urandom));
			endcase
			steady_in  = (p == 3);
			steady_out = (p == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				kind = $urandom_range(99);
				hdr  = ($urandom_range(99) < 85) ? HDR_BITS_HOST : 2'($urandom);
				cmd  = ($urandom_range(99) < 60) ? known[$urandom_range(5)] : 6'($urandom);
				f    = host_frame(hdr, cmd, $urandom);
				if (kind < 70) begin
					send_frame(f[47:24], f[23:0]);
				end else if (kind < 85) begin
					f = f ^ (48'h1 << $urandom_range(47));
					send_frame(f[47:24], f[23:0]);
				end else begin
					send_frame(word_t'($urandom), word_t'($urandom));
				end
			end
			drain_replies();
		end
		steady_in  = 1'b0;
		steady_out = 1'b0;
	endtask

	// Hold the result side off while frames keep coming
	task automatic test_backpressure();
		steady_in   = 1'b1;
		holdoff_req = 1'b1;
		for (int n = 0; n < 30; n++) begin
			send_cmd(HDR_BITS_HOST, (n % 3 == 0) ? CMD_APP_CMD : 6'($urandom), $urandom);
		end
		steady_in = 1'b0;
		drain_replies();
	endtask

	// Result side stall: random, steady, or a counted hold-off
	always @(posedge clk) begin
		if (holdoff_req) begin
			holdoff_left = HOLDOFF_LEN;
			holdoff_req  = 1'b0;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			out_stall <= 1'b1;
		end else if (steady_out) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 29);
		end
	end

	// Compare each result beat with the oldest pending reply
	always @(posedge clk) begin
		reply_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				$error("result beat with no reply pending: status %0d", status);
				errors++;
			end else begin
				exp_r = pending_replies.pop_front();
				if (status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, status);
					errors++;
				end
				if (resp_first !== exp_r.resp_first) begin
					$error("resp_first: expected %06h, got %06h", exp_r.resp_first, resp_first);
					errors++;
				end
				if (resp_second !== exp_r.resp_second) begin
					$error("resp_second: expected %06h, got %06h",
						exp_r.resp_second, resp_second);
					errors++;
				end
				if (app_mode_out !== exp_r.app_mode) begin
					$error("app_mode_out: expected %0b, got %0b", exp_r.app_mode, app_mode_out);
					errors++;
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("sd_command_responder_core test failed");
			$finish;
		end
	end

	initial begin
		errors            = 0;
		cycles            = 0;
		card_state_mirror = '0;
		app_mode_mirror   = 1'b0;
		steady_in         = 1'b0;
		steady_out        = 1'b0;
		holdoff_req       = 1'b0;
		holdoff_left      = 0;
		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		in_valid    <= 1'b0;
		word_first  <= '0;
		word_second <= '0;
		out_stall   <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_config();
		test_backpressure();
		test_random();
		test_backpressure();

		drain_replies();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("sd_command_responder_core test passed");
		end else begin
			$display("sd_command_responder_core test failed");
		end
		$finish;
	end

endmodule
